@@ sv/wsm_pkg.sv @@
// shared constants and types for the wildcard string matcher
package wsm_pkg;

	// pattern and text limits
	localparam int MAX_PATTERN = 32;
	localparam int MAX_TEXT    = 65536;
	localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int POS_W       = $clog2(MAX_TEXT + 1);
	localparam int WIN_BITS    = MAX_PATTERN * 8;

	// field widths fixed by the stream format
	localparam int SYM_W       = 8;
	localparam int POSITION_W  = 5;
	localparam int IDX_W       = 16;
	localparam int CNT_W       = 17;
	localparam int CFG_LEN_W   = 6;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 40;

	// saturation limits
	localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(65536);
	localparam logic [IDX_W-1:0] INDEX_LIMIT = IDX_W'(65535);

	// reset values of the configuration registers
	localparam logic [CFG_LEN_W-1:0] LEN_RESET = CFG_LEN_W'(1);
	localparam logic [SYM_W-1:0]     WC_RESET  = SYM_W'(63);

	typedef logic [SYM_W-1:0] sym_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEXT = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LENGTH   = 2'd0,
		CFG_WILDCARD_SYMBOL  = 2'd1,
		CFG_FIRST_MATCH_ONLY = 2'd2
	} cfg_reg_t;

endpackage

@@ sv/wildcard_string_matcher.sv @@
// wildcard string matcher: pattern store, text window, parallel compare, result register
//
// Usage:
//   Input beats on s_axis carry either a pattern byte load (tuser = 0) or a
//   text byte (tuser = 1). A load writes the pattern byte at the given
//   position and produces no output beat. Each text byte produces exactly
//   one output beat on m_axis with the match flag, the start index of the
//   occurrence ending at this byte, and the running match count; tlast on
//   the input marks the final byte of a text and is echoed on the output.
//   The user must write the configuration port (pattern length, wildcard symbol,
//   first-match mode) only while no beats are in flight; the block does not enforce it.
//   A text byte passes the input register, then the result register, on its way
//   to m_axis. Throughput is one beat per cycle while m_axis does not stall,
//   loads and text bytes alike; the window shift, the 32-lane byte compare and
//   the count update all sit in the single stage between the two registers.
//   When m_axis stalls the result register holds and the input register
//   fills; s_axis_tready drops only once both are occupied.
//   Reset clears the window and counters and loads the configuration defaults;
//   the pattern store holds no defined value until it is written.
module wildcard_string_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [wsm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // position[4:0], symbol[12:5], zero pad
	input  logic                             s_axis_tlast,  // text_last
	input  logic                             s_axis_tuser,  // operation
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [wsm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // match_found[0], match_index[16:1],
	                                                        // match_count[33:17], zero pad
	output logic                             m_axis_tlast,  // text_done
	// configuration
	input  logic                             cfg_we,
	input  logic [wsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wsm_pkg::*;

	// configuration registers
	logic [CFG_LEN_W-1:0] len_q;
	sym_t                 wc_q;
	logic                 fmo_q;

	// input stage
	logic                  valid_s1;
	op_t                   op_s1;
	logic [POSITION_W-1:0] pos_s1;
	sym_t                  sym_s1;
	logic                  last_s1;

	// result stage
	logic             valid_s2;
	logic             found_s2;
	logic [IDX_W-1:0] index_s2;
	logic [CNT_W-1:0] count_s2;
	logic             done_s2;

	// matcher state
	sym_t             pat_q [MAX_PATTERN];
	sym_t             win_q [MAX_PATTERN];
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic             first_q;

	// datapath
	logic                 out_free;
	logic                 adv_s1;
	logic                 text_adv;
	sym_t                 win_next [MAX_PATTERN];
	logic [LEN_W-1:0]     m_len;
	logic [LEN_W-1:0]     sh_full;
	logic [PAT_IDX_W-1:0] sh_amt;
	logic [WIN_BITS-1:0]  win_rev;
	logic [WIN_BITS-1:0]  win_aligned;
	logic [MAX_PATTERN-1:0] lane_ok;
	logic                 win_match;
	logic [POS_W-1:0]     pos_next;
	logic [POS_W-1:0]     start_full;
	logic [IDX_W-1:0]     start_idx;
	logic                 hit;
	logic                 report;
	logic [CNT_W-1:0]     cnt_next;

	// handshake
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && ((op_s1 == OP_LOAD) || out_free);
	assign text_adv      = adv_s1 && (op_s1 == OP_TEXT);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			wc_q  <= WC_RESET;
			fmo_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LENGTH:   len_q <= cfg_data[CFG_LEN_W-1:0];
				CFG_WILDCARD_SYMBOL:  wc_q  <= cfg_data;
				CFG_FIRST_MATCH_ONLY: fmo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= op_t'(s_axis_tuser);
			pos_s1  <= s_axis_tdata[POSITION_W-1:0];
			sym_s1  <= s_axis_tdata[POSITION_W +: SYM_W];
			last_s1 <= s_axis_tlast;
		end
	end

	// pattern store, written by loads
	always_ff @(posedge clk) begin
		if (adv_s1 && (op_s1 == OP_LOAD) && (32'(pos_s1) < MAX_PATTERN)) begin
			pat_q[pos_s1[PAT_IDX_W-1:0]] <= sym_s1;
		end
	end

	// effective pattern length, clamped to 1..MAX_PATTERN
	always_comb begin
		if (len_q == '0) begin
			m_len = LEN_W'(1);
		end else if (32'(len_q) > MAX_PATTERN) begin
			m_len = LEN_W'(MAX_PATTERN);
		end else begin
			m_len = LEN_W'(len_q);
		end
	end

	// window after shifting in the new byte, entry 0 newest
	always_comb begin
		win_next[0] = sym_s1;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// oldest-first view, shifted so the newest m bytes line up with pattern lanes
	assign sh_full = LEN_W'(MAX_PATTERN) - m_len;
	assign sh_amt  = sh_full[PAT_IDX_W-1:0];

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			win_rev[8*k +: 8] = win_next[MAX_PATTERN-1-k];
		end
	end

	assign win_aligned = win_rev >> {sh_amt, 3'b000};

	// per-lane compare with wildcard on either side
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			lane_ok[j] = (LEN_W'(j) >= m_len)
				|| (win_aligned[8*j +: 8] == pat_q[j])
				|| (win_aligned[8*j +: 8] == wc_q)
				|| (pat_q[j] == wc_q);
		end
	end

	assign win_match = &lane_ok;

	// position, start index and count
	assign pos_next   = (pos_q < POS_W'(MAX_TEXT)) ? pos_q + POS_W'(1) : pos_q;
	assign hit        = (pos_next >= POS_W'(m_len)) && win_match;
	assign report     = hit && !(fmo_q && first_q);
	assign start_full = pos_next - POS_W'(m_len);
	assign start_idx  = (start_full > POS_W'(INDEX_LIMIT)) ? INDEX_LIMIT
	                                                       : start_full[IDX_W-1:0];
	assign cnt_next   = (report && (cnt_q < COUNT_LIMIT)) ? cnt_q + CNT_W'(1) : cnt_q;

	// text state, cleared after the last byte of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= '0;
			end
			pos_q   <= '0;
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else if (text_adv) begin
			if (last_s1) begin
				for (int i = 0; i < MAX_PATTERN; i++) begin
					win_q[i] <= '0;
				end
				pos_q   <= '0;
				cnt_q   <= '0;
				first_q <= 1'b0;
			end else begin
				for (int i = 0; i < MAX_PATTERN; i++) begin
					win_q[i] <= win_next[i];
				end
				pos_q   <= pos_next;
				cnt_q   <= cnt_next;
				first_q <= first_q || hit;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (text_adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_adv) begin
			found_s2 <= report;
			index_s2 <= report ? start_idx : '0;
			count_s2 <= cnt_next;
			done_s2  <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W - 1 - IDX_W - CNT_W){1'b0}}, count_s2, index_s2, found_s2};
	assign m_axis_tlast  = done_s2;

	// a reported match is always counted
	a_found_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && found_s2) |-> (count_s2 != '0))
		else $error("match reported with zero count");

	// no index without a match
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !found_s2) |-> (index_s2 == '0))
		else $error("nonzero index without a match");

	// first-match mode suppresses later matches
	a_first_only: assert property (@(posedge clk) disable iff (!arst_n)
		(text_adv && fmo_q && first_q) |=> !found_s2)
		else $error("second match reported in first-match mode");

	// end of text clears the running state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(text_adv && last_s1) |=> ((pos_q == '0) && (cnt_q == '0) && !first_q))
		else $error("text state not cleared after last byte");

endmodule
